// File: hdl/smavg_pkg.sv
package smavg_pkg;

   // Field widths
   localparam int PRICE_W = 32;
   localparam int LEN_W   = 5;

   // Defaults
   localparam int DEFAULT_MAX_WINDOW = 16;
   localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(10);

   // Input transaction
   typedef struct packed {
      logic               price_present;
      logic [PRICE_W-1:0] trade_price;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [PRICE_W-1:0] average;
      logic [LEN_W-1:0]   samples_held;
   } rsp_type;

endpackage

// File: hdl/simple_moving_average_top.sv
// Channel | Direction | Handshake               | Payload
// req     | in        | req_valid / req_stall   | smavg_pkg::req_type
// rsp     | out       | rsp_valid / rsp_stall   | smavg_pkg::rsp_type
// csr     | in        | csr_valid / csr_ready   | window_length (5 bits)
//
// A tick with a price passes CHECK, WRITE, the one-bit-per-cycle restoring
// divider and FINISH before the next accept; a full window first drops its
// oldest price in READ. A tick without a price goes straight to FINISH.
// One transaction is in flight at a time.
// Reset is synchronous, active high: window empty, window_length = 10.
// The price memory is not cleared; only written entries are ever read.
// The result sits in an output register; a stalled rsp holds the block
// in its final state until the register frees up.
module simple_moving_average_top #(
   parameter int MAX_WINDOW = smavg_pkg::DEFAULT_MAX_WINDOW
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  smavg_pkg::req_type           req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output smavg_pkg::rsp_type           rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [smavg_pkg::LEN_W-1:0]  csr_data
);
   import smavg_pkg::*;

   localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W  = PRICE_W + ADDR_W;
   localparam int CNT_W  = $clog2(SUM_W + 1);
   localparam int CAP    = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
   localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAP);
   localparam int WRAP_W = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;
   localparam logic [WRAP_W-1:0] MAX_L  = WRAP_W'(MAX_WINDOW);
   localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(MAX_WINDOW - 1);
   localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(SUM_W);

   // Sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic [LEN_W-1:0]   held_ff, held_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [PRICE_W-1:0] rd_data_ff;
   logic [PRICE_W-1:0] mem [MAX_WINDOW];

   logic               req_take;
   logic               csr_take;
   logic               out_free;
   logic [LEN_W-1:0]   eff_len;
   logic [WRAP_W-1:0]  slot_w, held_w, oldest_w;
   logic [ADDR_W-1:0]  oldest_addr;
   logic [LEN_W:0]     rem_sh, rem_diff;

   // Handshakes
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_take  = csr_valid && csr_ready;
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Effective window length: zero means one, saturate at capacity
   always_comb begin
      if (length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (length_ff > CAP_L) begin
         eff_len = CAP_L;
      end else begin
         eff_len = length_ff;
      end
   end

   // Oldest entry: write slot minus count, modulo the depth
   assign slot_w = WRAP_W'(slot_ff);
   assign held_w = WRAP_W'(held_ff);
   always_comb begin
      if (slot_w >= held_w) begin
         oldest_w = slot_w - held_w;
      end else begin
         oldest_w = slot_w + MAX_L - held_w;
      end
   end
   assign oldest_addr = oldest_w[ADDR_W-1:0];

   // Restoring divider step
   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, held_ff};

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      slot_in      = slot_ff;
      held_in      = held_ff;
      sum_in       = sum_ff;
      price_in     = price_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               length_in = csr_data;
               slot_in   = '0;
               held_in   = '0;
               sum_in    = '0;
            end else if (req_take) begin
               price_in = req_data.trade_price;
               if (req_data.price_present) begin
                  state_in = ST_CHECK;
               end else begin
                  quo_in   = '0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_CHECK: begin
            // memory read of the oldest entry is launched here
            if ((held_ff >= eff_len) && (held_ff != '0)) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_READ: begin
            sum_in   = sum_ff - SUM_W'(rd_data_ff);
            held_in  = held_ff - LEN_W'(1);
            state_in = ST_CHECK;
         end
         ST_WRITE: begin
            slot_in  = (slot_ff == LAST_A) ? '0 : slot_ff + ADDR_W'(1);
            held_in  = held_ff + LEN_W'(1);
            sum_in   = sum_ff + SUM_W'(price_ff);
            quo_in   = sum_ff + SUM_W'(price_ff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, held_ff}) begin
               rem_in = rem_diff[LEN_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[LEN_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_STEPS - CNT_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_in.average      = quo_ff[PRICE_W-1:0];
               rsp_in.samples_held = held_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= WINDOW_RESET;
         slot_ff      <= '0;
         held_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         slot_ff      <= slot_in;
         held_ff      <= held_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      price_ff <= price_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   // Price window memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         mem[slot_ff] <= price_ff;
      end
      if (state_ff == ST_CHECK) begin
         rd_data_ff <= mem[oldest_addr];
      end
   end

   // Checks
   a_held_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CAP_L)
      else $error("held count above window capacity");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (held_ff != '0))
      else $error("divide by zero count");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (held_ff != '0))
      else $error("drop from empty window");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_take |=> (held_ff == '0) && (sum_ff == '0) && (state_ff == ST_IDLE))
      else $error("window not cleared by length write");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0) |-> (sum_ff == '0))
      else $error("empty window with nonzero sum");

endmodule
